/* design/firlp_pkg.sv */
// Shared types, constants and the coefficient table of the low-pass FIR.
package firlp_pkg;

  localparam int COEF_W         = 16;
  localparam int COEF_TABLE_LEN = 16;
  localparam int COEF_IDX_W     = 7;

  // Q1.15 low-pass taps; the first entry is deliberately not mirrored.
  localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_TABLE_LEN] = '{
    -16'sd108,  -16'sd172,  -16'sd225,  16'sd0,
     16'sd833,   16'sd2375,  16'sd4297,  16'sd5918,
     16'sd6554,  16'sd5918,  16'sd4297,  16'sd2375,
     16'sd833,   16'sd0,    -16'sd225,  -16'sd172
  };

  // Control from the sequencer to the tap ring.
  typedef struct packed {
    logic load;    // push a new sample in, drop the oldest
    logic rotate;  // advance the ring by one tap, bit-rotating the head
  } ring_ctrl_t;

  // Coefficient of tap n; taps past the table weigh zero.
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] n);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (n < COEF_IDX_W'(COEF_TABLE_LEN)) begin
      c = COEF_TABLE[n[3:0]];
    end
    return c;
  endfunction

endpackage

/* design/firlp_in_if.sv */
// Input channel: valid/ready handshake carrying one raw sample.
interface firlp_in_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

/* design/firlp_out_if.sv */
// Result channel: valid/ready handshake carrying one filtered sample.
interface firlp_out_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink   (input valid, input filtered_out, output ready);
endinterface

/* design/fir_lowpass_16tap_core.sv */
// Sample flow: input transfer, bit-serial accumulation (ST_MAC), rounding (ST_ROUND), then
// the registered result. A new sample is accepted only in ST_IDLE; the single bit-serial
//   multiply-accumulate visits every tap once per sample bit plane.
// A finished result waits in the output register while the next sample is taken in.
// Reset (synchronous, active low) clears the delay line, the sequencer and the output valid.
module fir_lowpass_16tap_core #(
  parameter int TAP_COUNT      = 16,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 15
) (
  input logic        clk,
  input logic        rst_n,
  firlp_in_if.sink   in_if,
  firlp_out_if.source out_if
);

  // Sum of |coef| is below 2^16, so SAMPLE_WIDTH+17 bits hold any partial sum;
  // one spare bit covers the rounding offset.
  localparam int ACC_W = SAMPLE_WIDTH + 18;
  localparam int TW    = $clog2(TAP_COUNT);
  localparam int BW    = $clog2(SAMPLE_WIDTH);

  localparam logic [TW-1:0] TAP_LAST   = TW'(TAP_COUNT - 1);
  localparam logic [BW-1:0] PLANE_LAST = BW'(SAMPLE_WIDTH - 1);

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    ACC_W'(1) << (COEF_FRAC_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND
  } state_t;

  state_t                         st_r;
  logic [TW-1:0]                  tap_cnt_r;
  logic [BW-1:0]                  plane_cnt_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_data_r;

  firlp_pkg::ring_ctrl_t          ring_ctrl;
  logic                           head_bit;
  logic                           in_xfer;
  logic                           out_free;
  logic                           out_load;
  logic                           mac_last;
  logic signed [firlp_pkg::COEF_W-1:0] coef;
  logic signed [ACC_W-1:0]        coef_ext;
  logic signed [ACC_W-1:0]        acc_base;
  logic signed [ACC_W-1:0]        acc_nxt;
  logic signed [ACC_W-1:0]        rounded;
  logic signed [ACC_W-1:0]        scaled;
  logic signed [SAMPLE_WIDTH-1:0] sat_out;

  // Accept a new sample only between items; the output register decouples the sink.
  assign in_if.ready   = (st_r == ST_IDLE);
  assign in_xfer       = in_if.valid && in_if.ready;
  assign out_free      = !out_valid_r || out_if.ready;
  assign out_load      = (st_r == ST_ROUND) && out_free;
  assign out_if.valid  = out_valid_r;
  assign out_if.filtered_out = out_data_r;

  assign mac_last = (tap_cnt_r == TAP_LAST) && (plane_cnt_r == PLANE_LAST);

  always_comb begin
    ring_ctrl.load   = in_xfer;
    ring_ctrl.rotate = (st_r == ST_MAC);
  end

  firlp_tap_ring #(
    .TAP_COUNT    (TAP_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ring_ctrl),
    .sample   (in_if.sample_in),
    .head_bit (head_bit)
  );

  // Horner over bit planes, MSB first: double at the start of each plane, then add
  // each tap's coefficient where its bit is set. The sign plane subtracts.
  always_comb begin
    coef     = firlp_pkg::coef_at(firlp_pkg::COEF_IDX_W'(tap_cnt_r));
    coef_ext = {{(ACC_W-firlp_pkg::COEF_W){coef[firlp_pkg::COEF_W-1]}}, coef};
    acc_base = (tap_cnt_r == '0) ? (acc_r <<< 1) : acc_r;
    acc_nxt  = acc_base;
    if (head_bit) begin
      if (plane_cnt_r == '0) begin
        acc_nxt = acc_base - coef_ext;
      end else begin
        acc_nxt = acc_base + coef_ext;
      end
    end
  end

  // Round half up to the sample scale, then clamp to the signed sample range.
  always_comb begin
    rounded = acc_r + ROUND_HALF;
    scaled  = rounded >>> COEF_FRAC_BITS;
    if (scaled > SAT_HI) begin
      sat_out = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (scaled < SAT_LO) begin
      sat_out = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat_out = scaled[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      tap_cnt_r   <= '0;
      plane_cnt_r <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      // load a fresh result, else drop the held one once the sink has taken it
      if (out_load) begin
        out_data_r  <= sat_out;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_xfer) begin
            acc_r       <= '0;
            tap_cnt_r   <= '0;
            plane_cnt_r <= '0;
            st_r        <= ST_MAC;
          end
        end
        ST_MAC: begin
          acc_r <= acc_nxt;
          if (tap_cnt_r == TAP_LAST) begin
            tap_cnt_r   <= '0;
            plane_cnt_r <= mac_last ? '0 : plane_cnt_r + 1'b1;
          end else begin
            tap_cnt_r <= tap_cnt_r + 1'b1;
          end
          if (mac_last) begin
            st_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          // hold here until the output register is free
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A transfer in always starts the accumulation.
  a_xfer_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (st_r == ST_MAC))
    else $error("sample transfer did not start accumulation");

  // Counters sit at zero whenever no item is in flight.
  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (tap_cnt_r == '0 && plane_cnt_r == '0))
    else $error("tap or plane counter not cleared while idle");

  // The final tap of the final plane hands over to rounding.
  a_mac_ends_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MAC && mac_last) |=> (st_r == ST_ROUND))
    else $error("accumulation did not hand over to rounding");

  // Rounding with a free output register always yields a valid result.
  a_round_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROUND && out_free) |=> (out_valid_r && st_r == ST_IDLE))
    else $error("rounded result not loaded into output register");

  // Input is never taken while a result is still being computed.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MAC || st_r == ST_ROUND) |-> !in_if.ready)
    else $error("input ready raised during computation");

endmodule

/* design/firlp_tap_ring.sv */
// Delay line held as a rotating ring of samples, presenting one bit per cycle while rotating.
module firlp_tap_ring #(
  parameter int TAP_COUNT    = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  firlp_pkg::ring_ctrl_t          ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           head_bit
);

  logic [SAMPLE_WIDTH-1:0] ring_r   [TAP_COUNT];
  logic [SAMPLE_WIDTH-1:0] ring_nxt [TAP_COUNT];

  always_comb begin
    for (int i = 0; i < TAP_COUNT; i++) begin
      ring_nxt[i] = ring_r[i];
    end
    if (ctrl.load) begin
      // newest at slot 0, oldest falls off the end
      ring_nxt[0] = sample;
      for (int i = 1; i < TAP_COUNT; i++) begin
        ring_nxt[i] = ring_r[i-1];
      end
    end else if (ctrl.rotate) begin
      // head goes to the tail rotated left, so the next bit down surfaces next pass
      for (int i = 0; i < TAP_COUNT - 1; i++) begin
        ring_nxt[i] = ring_r[i+1];
      end
      ring_nxt[TAP_COUNT-1] = {ring_r[0][SAMPLE_WIDTH-2:0], ring_r[0][SAMPLE_WIDTH-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        ring_r[i] <= ring_nxt[i];
      end
    end
  end

  assign head_bit = ring_r[0][SAMPLE_WIDTH-1];

endmodule

/* verif/fir_lowpass_16tap_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the 16-tap low-pass FIR core, directed and random samples.
module fir_lowpass_16tap_core_tb;

  localparam int SW           = 16;
  localparam int TAPS         = 16;
  localparam int FRAC         = 15;
  // Time for one item: the bit-serial pass over all taps and bit planes, plus the load and the output stage.
  localparam int LATENCY      = TAPS * SW + 2;
  localparam int RANDOM_ITEMS = 1750;
  localparam int LONG_GAP     = 20;
  // Worst case per transfer: the block's own cycles plus the longest sender gap and
  // the longest receiver stall; take that three times over for the timeout.
  localparam int CYCLE_LIMIT  = (RANDOM_ITEMS + 40) * (LATENCY + 2 * LONG_GAP) * 3;
  // Window of accepted samples in which neither side starts a new random stall.
  localparam int QUIET_FROM   = 800;
  localparam int QUIET_TO     = 1100;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t S_MAX = 16'sh7fff;
  localparam sample_t S_MIN = 16'sh8000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Testbench-side drivers, known from time zero.
  logic    in_valid  = 1'b0;
  sample_t in_sample = '0;
  logic    out_ready = 1'b0;

  firlp_in_if  #(.W(SW)) in_ch ();
  firlp_out_if #(.W(SW)) out_ch ();

  assign in_ch.valid     = in_valid;
  assign in_ch.sample_in = in_sample;
  assign out_ch.ready    = out_ready;

  fir_lowpass_16tap_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Q1.15 low-pass taps, newest sample first; the first tap is not mirrored.
  int lp_coef [TAPS] = '{
    -108, -172, -225,    0,  833, 2375, 4297, 5918,
    6554, 5918, 4297, 2375,  833,    0, -225, -172
  };

  // Filter state as it stands after reset: zeroed history, write slot zero.
  sample_t    tap_hist [TAPS] = '{default: '0};
  logic [3:0] tap_head = 4'd0;

  sample_t samples_pending [$];
  sample_t filtered_due [$];

  logic    in_taken = 1'b0;
  int      send_gap = 0;
  int      recv_gap = 0;
  int      n_in     = 0;
  int      n_out    = 0;
  int      n_hi     = 0;
  int      n_lo     = 0;
  int      n_err    = 0;
  int      cycle_cnt = 0;
  sample_t want;
  sample_t got;
  logic    quiet;

  assign quiet = (n_in >= QUIET_FROM) && (n_in < QUIET_TO);

  // Push one sample into the history and return the filtered output it causes:
  // full-width MAC, add half an LSB, floor shift, clamp to the sample range.
  function automatic sample_t lowpass_next(input sample_t x);
    longint     acc;
    logic [3:0] idx;
    acc = 0;
    tap_hist[tap_head] = x;
    tap_head = tap_head + 4'd1;
    for (int n = 0; n < TAPS; n++) begin
      idx = tap_head - 4'd1 - 4'(n);
      acc += longint'(lp_coef[n]) * longint'(tap_hist[idx]);
    end
    acc = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
    if (acc > longint'(S_MAX)) begin
      acc = longint'(S_MAX);
    end
    if (acc < longint'(S_MIN)) begin
      acc = longint'(S_MIN);
    end
    return sample_t'(acc);
  endfunction

  // Queue a full window of extremes lined up with the tap signs, so that every product
  // with a nonzero tap pulls the same way and the rounded sum clamps at one end.
  task automatic add_window(input bit negative);
    for (int n = TAPS - 1; n >= 0; n--) begin
      if (lp_coef[n] == 0) begin
        samples_pending.push_back(sample_t'($urandom));
      end else if ((lp_coef[n] < 0) != negative) begin
        samples_pending.push_back(S_MIN);
      end else begin
        samples_pending.push_back(S_MAX);
      end
    end
  endtask

  // Decide whether one side holds off this cycle; now and then start a longer gap.
  function automatic bit stall_now(inout int gap);
    bit hold;
    hold = 1'b0;
    if (gap > 0) begin
      gap--;
      hold = 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      hold = 1'b1;
      if ($urandom_range(0, 99) < 1) begin
        gap = $urandom_range(1, LONG_GAP);
      end
    end
    return hold;
  endfunction

  task automatic flag_mismatch(input string what, input sample_t exp_v, input sample_t act_v);
    n_err++;
    if (n_err <= 10) begin
      $display("%s at result %0d: expected %0d, got %0d", what, n_out, exp_v, act_v);
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // Driver: change inputs on the falling edge. Hold the current sample until its
  // transfer, then either present the next one or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (samples_pending.size() != 0 && !stall_now(send_gap)) begin
        in_valid  <= 1'b1;
        in_sample <= samples_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure; stalls leave a finished result waiting
  // while the next sample goes in.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !stall_now(recv_gap);
    end
  end

  // Monitor: sample both channels on the rising edge. Predict on every input
  // transfer, and check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        filtered_due.push_back(lowpass_next(in_ch.sample_in));
        n_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.filtered_out;
        n_out++;
        if (got == S_MAX) begin
          n_hi++;
        end
        if (got == S_MIN) begin
          n_lo++;
        end
        if (filtered_due.size() == 0) begin
          flag_mismatch("unexpected result", 'x, got);
        end else begin
          want = filtered_due.pop_front();
          if (got !== want) begin
            flag_mismatch("filtered_out", want, got);
          end
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, filtered_due.size());
      $display("fir_lowpass_16tap_core: mismatch");
      $finish;
    end
  end

  initial begin
    int      kind;
    int      run;
    int      target;
    int      total_items;
    sample_t v;

    // Directed part. From a cleared history, 4096 then -32768 land both of the
    // first two sums exactly on a half LSB (one negative, one positive tie).
    samples_pending.push_back(16'sd4096);
    samples_pending.push_back(S_MIN);
    samples_pending.push_back(S_MAX);
    samples_pending.push_back(16'sd0);
    samples_pending.push_back(-16'sd1);
    samples_pending.push_back(16'sd1);
    // Sign-aligned extremes over the whole window: clamp at the top end.
    add_window(1'b0);

    // Random part, built from short runs of different character.
    target = samples_pending.size() + RANDOM_ITEMS;
    while (samples_pending.size() < target) begin
      kind = $urandom_range(0, 9);
      case (kind)
        4, 5: begin
          add_window(1'($urandom_range(0, 1)));
        end
        6: begin
          // small values around zero exercise the rounding
          run = $urandom_range(8, 24);
          repeat (run) samples_pending.push_back(sample_t'(int'($urandom_range(0, 8)) - 4));
        end
        7: begin
          // step: hold one level long enough to settle
          v = sample_t'($urandom);
          run = $urandom_range(16, 24);
          repeat (run) samples_pending.push_back(v);
        end
        8: begin
          run = $urandom_range(4, 20);
          repeat (run) samples_pending.push_back($urandom_range(0, 1) ? S_MAX : S_MIN);
        end
        9: begin
          // impulse: one value, then flush it through every tap
          samples_pending.push_back(sample_t'($urandom));
          repeat (TAPS - 1) samples_pending.push_back('0);
        end
        default: begin
          run = $urandom_range(1, 24);
          repeat (run) samples_pending.push_back(sample_t'($urandom));
        end
      endcase
    end
    total_items = samples_pending.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: wait until a result has come back for every queued sample.
    while (n_out < total_items) @(negedge clk);
    // Then keep watching for any stray result.
    repeat (LATENCY + 40) @(negedge clk);

    $display("%0d samples transferred, %0d results checked", n_in, n_out);
    $display("outputs clamped high %0d, clamped low %0d, mismatches %0d", n_hi, n_lo, n_err);
    if (n_err == 0 && filtered_due.size() == 0) begin
      $display("fir_lowpass_16tap_core: match");
    end else begin
      $display("fir_lowpass_16tap_core: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
design/firlp_pkg.sv
design/firlp_in_if.sv
design/firlp_out_if.sv
design/firlp_tap_ring.sv
design/fir_lowpass_16tap_core.sv
verif/fir_lowpass_16tap_core_tb.sv
